@@ hw/rtl/jndg_pkg.sv @@
// shared constants for the json nesting depth guard
package jndg_pkg;

   localparam int unsigned DEPTH_W = 8;
   localparam int unsigned BYTES_W = 24;
   localparam int unsigned COUNT_W = BYTES_W + 1;
   localparam int unsigned INDEX_W = 1;

   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET  = 8'd64;
   localparam logic [BYTES_W-1:0] LENGTH_LIMIT_RESET = 24'h100000;
   localparam logic [COUNT_W-1:0] COUNT_SAT          = {COUNT_W{1'b1}};

   // register indexes on the configuration port
   localparam logic [INDEX_W-1:0] CSR_DEPTH_LIMIT  = 1'b0;
   localparam logic [INDEX_W-1:0] CSR_LENGTH_LIMIT = 1'b1;

   // byte codes
   localparam logic [7:0] CHR_OPEN_BRACE    = 8'h7B;
   localparam logic [7:0] CHR_OPEN_BRACKET  = 8'h5B;
   localparam logic [7:0] CHR_CLOSE_BRACE   = 8'h7D;
   localparam logic [7:0] CHR_CLOSE_BRACKET = 8'h5D;
   localparam logic [7:0] CHR_QUOTE         = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH     = 8'h5C;
   localparam logic [7:0] CHR_NUL           = 8'h00;

endpackage

@@ hw/rtl/json_nesting_depth_guard.sv @@
// json nesting depth guard: screens a byte stream for depth, length and zero bytes
//
// Input channel req_: one document byte per transfer (req_data_byte), with
// req_last_byte high on the final byte. Documents are never empty.
// Result channel rsp_: exactly one transfer per document, rsp_accepted high
// when the document is safe to parse, low when it was rejected.
// Configuration channel csr_: index 0 writes the depth limit (8 bits, low bits
// of csr_data), index 1 writes the length limit (24 bits). csr_ready is always
// high; write only while no document byte is in flight.
// A byte is captured in an input register and evaluated there against the
// document state; a final byte's verdict is registered in the result register,
// which drives rsp_valid.
// Throughput: one byte per cycle, except while req_stall holds a final byte.
// When the receiver stalls with a verdict waiting, non-final bytes keep
// flowing; a further final byte waits in the input register and
// req_stall rises until the verdict is taken.
// Reset: synchronous, active high; clears the document state and restores
// the depth limit to 64 and the length limit to 1048576.
module json_nesting_depth_guard
   import jndg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [BYTES_W-1:0] csr_data
);

   logic [DEPTH_W-1:0] depth_limit_ff;
   logic [BYTES_W-1:0] length_limit_ff;

   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_last_ff;

   logic               inside_string_ff, inside_string_in;
   logic               escape_pending_ff, escape_pending_in;
   logic [DEPTH_W-1:0] nesting_level_ff, nesting_level_in;
   logic [COUNT_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic               rejected_flag_ff, rejected_flag_in;

   logic               rsp_valid_ff;
   logic               rsp_accepted_ff;

   logic               s1_advance;
   logic               req_take;
   logic [COUNT_W-1:0] count_next;
   logic [DEPTH_W:0]   depth_plus;
   logic               reject_now;

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff  <= DEPTH_LIMIT_RESET;
         length_limit_ff <= LENGTH_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEPTH_LIMIT:  depth_limit_ff  <= csr_data[DEPTH_W-1:0];
            CSR_LENGTH_LIMIT: length_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // document state update
   always_comb begin
      count_next = (bytes_seen_ff == COUNT_SAT) ? bytes_seen_ff
                                                : bytes_seen_ff + 1'b1;
      depth_plus = {1'b0, nesting_level_ff} + 1'b1;
      reject_now = rejected_flag_ff || (count_next > {1'b0, length_limit_ff})
                   || (s1_byte_ff == CHR_NUL);

      inside_string_in  = inside_string_ff;
      escape_pending_in = escape_pending_ff;
      nesting_level_in  = nesting_level_ff;
      bytes_seen_in     = count_next;
      rejected_flag_in  = reject_now;

      if (!reject_now) begin
         if (inside_string_ff) begin
            if (escape_pending_ff) begin
               escape_pending_in = 1'b0;
            end else if (s1_byte_ff == CHR_BACKSLASH) begin
               escape_pending_in = 1'b1;
            end else if (s1_byte_ff == CHR_QUOTE) begin
               inside_string_in = 1'b0;
            end
         end else if (s1_byte_ff == CHR_QUOTE) begin
            inside_string_in = 1'b1;
         end else if (s1_byte_ff == CHR_OPEN_BRACE || s1_byte_ff == CHR_OPEN_BRACKET) begin
            if (depth_plus > {1'b0, depth_limit_ff}) begin
               rejected_flag_in = 1'b1;
            end else begin
               nesting_level_in = depth_plus[DEPTH_W-1:0];
            end
         end else if (s1_byte_ff == CHR_CLOSE_BRACE || s1_byte_ff == CHR_CLOSE_BRACKET) begin
            if (nesting_level_ff != '0) begin
               nesting_level_in = nesting_level_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_string_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
         nesting_level_ff  <= '0;
         bytes_seen_ff     <= '0;
         rejected_flag_ff  <= 1'b0;
      end else if (s1_advance) begin
         if (s1_last_ff) begin
            inside_string_ff  <= 1'b0;
            escape_pending_ff <= 1'b0;
            nesting_level_ff  <= '0;
            bytes_seen_ff     <= '0;
            rejected_flag_ff  <= 1'b0;
         end else begin
            inside_string_ff  <= inside_string_in;
            escape_pending_ff <= escape_pending_in;
            nesting_level_ff  <= nesting_level_in;
            bytes_seen_ff     <= bytes_seen_in;
            rejected_flag_ff  <= rejected_flag_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_accepted_ff <= !rejected_flag_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_escape_in_string: assert property (@(posedge clock) disable iff (reset)
      escape_pending_ff |-> inside_string_ff)
      else $error("escape pending outside a string");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a waiting verdict");

   a_verdict_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance && s1_last_ff))
      else $error("verdict without a final byte");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=>
         (bytes_seen_ff == '0 && nesting_level_ff == '0 && !rejected_flag_ff
          && !inside_string_ff))
      else $error("document state not cleared after final byte");
`endif

endmodule

@@ test/tb_json_nesting_depth_guard.sv @@
// testbench for the json nesting depth guard: predicted verdicts checked against the block
`timescale 1ns / 100ps

module tb_json_nesting_depth_guard;
   import jndg_pkg::*;

   localparam int unsigned CLOCK_PERIOD = 20;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned MAX_WAIT     = 18;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned BYTE_BUDGET  = 1900;
   localparam int unsigned PHASE_BYTES  = 100;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam longint     TIMEOUT_NS   = 64'd10_000_000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } doc_byte_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = '0;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic               rsp_accepted;
   logic               csr_valid     = 1'b0;
   logic               csr_ready;
   logic [INDEX_W-1:0] csr_index     = CSR_DEPTH_LIMIT;
   logic [BYTES_W-1:0] csr_data      = '0;

   json_nesting_depth_guard DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_accepted  (rsp_accepted),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // predictor copy of limits and document state
   logic [DEPTH_W-1:0] lim_depth;
   logic [BYTES_W-1:0] lim_bytes;
   logic               str_open;
   logic               in_escape;
   logic               doc_rejected;
   logic [DEPTH_W-1:0] depth_level;
   logic [COUNT_W-1:0] byte_count;

   doc_byte_type pending_bytes[$];
   logic        expected_verdicts[$];
   int unsigned documents_queued  = 0;
   int unsigned bytes_queued      = 0;
   int unsigned verdicts_received = 0;
   int unsigned mismatches        = 0;

   logic        req_fire    = 1'b0;
   logic        rsp_fire    = 1'b0;
   logic        rsp_present = 1'b0;
   int unsigned req_gap     = 0;
   int unsigned rsp_hold    = 0;
   logic        req_calm    = 1'b0;
   logic        rsp_calm    = 1'b0;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned draw_wait(input logic calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic clear_document();
      str_open     = 1'b0;
      in_escape    = 1'b0;
      doc_rejected = 1'b0;
      depth_level  = '0;
      byte_count   = '0;
   endtask

   task automatic screen_byte(input logic [7:0] c, input logic last);
      if (byte_count != COUNT_SAT) byte_count = byte_count + 1'b1;
      if (byte_count > {1'b0, lim_bytes}) doc_rejected = 1'b1;
      if (c == CHR_NUL) doc_rejected = 1'b1;
      if (!doc_rejected) begin
         if (str_open) begin
            if (in_escape) in_escape = 1'b0;
            else if (c == CHR_BACKSLASH) in_escape = 1'b1;
            else if (c == CHR_QUOTE) str_open = 1'b0;
         end else if (c == CHR_QUOTE) begin
            str_open = 1'b1;
         end else if (c == CHR_OPEN_BRACE || c == CHR_OPEN_BRACKET) begin
            if ({1'b0, depth_level} + 9'd1 > {1'b0, lim_depth}) doc_rejected = 1'b1;
            else depth_level = depth_level + 1'b1;
         end else if (c == CHR_CLOSE_BRACE || c == CHR_CLOSE_BRACKET) begin
            if (depth_level != '0) depth_level = depth_level - 1'b1;
         end
      end
      if (last) begin
         expected_verdicts.push_back(!doc_rejected);
         clear_document();
      end
   endtask

   task automatic check_verdict(input logic got);
      logic want;
      verdicts_received++;
      if (expected_verdicts.size() == 0) begin
         if (mismatches < MAX_REPORTS) $display("verdict with none expected: got %0b", got);
         mismatches++;
      end else begin
         want = expected_verdicts.pop_front();
         if (got !== want) begin
            if (mismatches < MAX_REPORTS)
               $display("verdict mismatch: expected %0b, got %0b", want, got);
            mismatches++;
         end
      end
   endtask

   // sampling side: transfers, register writes, prediction and checking
   always @(posedge clock) begin
      if (reset) begin
         lim_depth   = DEPTH_LIMIT_RESET;
         lim_bytes   = LENGTH_LIMIT_RESET;
         clear_document();
         req_fire    = 1'b0;
         rsp_fire    = 1'b0;
         rsp_present = 1'b0;
      end else begin
         req_fire    = req_valid && !req_stall;
         rsp_fire    = rsp_valid && !rsp_stall;
         rsp_present = rsp_valid;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEPTH_LIMIT:  lim_depth = csr_data[DEPTH_W-1:0];
               CSR_LENGTH_LIMIT: lim_bytes = csr_data;
               default: ;
            endcase
         end
         if (rsp_fire) check_verdict(rsp_accepted);
         if (req_fire) screen_byte(req_data_byte, req_last_byte);
      end
   end

   // byte driver
   always @(negedge clock) begin : byte_driver
      doc_byte_type next_byte;
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_byte = pending_bytes.pop_front();
               req_data_byte <= next_byte.data;
               req_last_byte <= next_byte.last;
               req_valid     <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
               req_gap = draw_wait(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // verdict receiver stall
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            if ($urandom_range(0, 9) == 0) rsp_calm = !rsp_calm;
            rsp_hold = draw_wait(rsp_calm);
         end else if (rsp_present && rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      doc_byte_type item;
      item.data = b;
      item.last = last;
      pending_bytes.push_back(item);
      bytes_queued++;
      if (last) documents_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] index,
                                 input logic [BYTES_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_idle();
      while (verdicts_received < documents_queued) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly well-formed documents, some noise and some broken ones
   task automatic queue_document(input int unsigned depth_cap);
      logic [7:0]  doc[$];
      logic [7:0]  closers[$];
      logic [7:0]  b;
      int unsigned target;
      int unsigned goal;
      int unsigned style;
      int unsigned k;
      style  = $urandom_range(0, 9);
      target = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      if (style == 7) begin
         repeat (target) doc.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 19) == 0) begin
            // deep nesting up to or just past the limit
            goal = depth_cap + $urandom_range(0, 1);
            repeat (goal) begin
               doc.push_back(CHR_OPEN_BRACKET);
               closers.push_back(CHR_CLOSE_BRACKET);
            end
         end else begin
            goal = $urandom_range(0, (depth_cap < 6) ? depth_cap + 1 : 6);
         end
         while (doc.size() < target) begin
            case ($urandom_range(0, 4))
               0: begin
                  if (closers.size() < goal) begin
                     if ($urandom_range(0, 1)) begin
                        doc.push_back(CHR_OPEN_BRACE);
                        closers.push_back(CHR_CLOSE_BRACE);
                     end else begin
                        doc.push_back(CHR_OPEN_BRACKET);
                        closers.push_back(CHR_CLOSE_BRACKET);
                     end
                  end
               end
               1: begin
                  if (closers.size() != 0) doc.push_back(closers.pop_back());
               end
               2: begin
                  doc.push_back(CHR_QUOTE);
                  repeat ($urandom_range(0, 6)) begin
                     if ($urandom_range(0, 4) == 0) begin
                        doc.push_back(CHR_BACKSLASH);
                        doc.push_back(8'($urandom_range(1, 255)));
                     end else begin
                        b = 8'($urandom_range(1, 255));
                        if (b == CHR_QUOTE || b == CHR_BACKSLASH) b = 8'h61;
                        doc.push_back(b);
                     end
                  end
                  doc.push_back(CHR_QUOTE);
               end
               default: begin
                  b = 8'($urandom_range(8'h20, 8'h7E));
                  if (b == CHR_QUOTE || b == CHR_BACKSLASH || b == CHR_OPEN_BRACE ||
                      b == CHR_OPEN_BRACKET || b == CHR_CLOSE_BRACE ||
                      b == CHR_CLOSE_BRACKET) b = 8'h2C;
                  doc.push_back(b);
               end
            endcase
         end
         while (closers.size() != 0) doc.push_back(closers.pop_back());
         if (style >= 8) begin
            case ($urandom_range(0, 3))
               0: doc[$urandom_range(0, doc.size() - 1)] = CHR_NUL;
               1: begin
                  k = $urandom_range(1, doc.size());
                  while (doc.size() > k) void'(doc.pop_back());
               end
               2: repeat ($urandom_range(1, 3)) doc.push_front(CHR_CLOSE_BRACE);
               default: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
            endcase
         end
      end
      foreach (doc[i]) push_byte(doc[i], i == doc.size() - 1);
   endtask

   initial begin
      int unsigned        phase;
      int unsigned        phase_start;
      logic [7:0]         depth;
      logic [BYTES_W-1:0] limit;
      logic [BYTES_W-1:0] word;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed documents at the reset limits
      queue_text("{");
      queue_text("}]{}");
      queue_text("\"\\\"{\"]");
      queue_text("\"\\");
      push_byte(CHR_QUOTE, 1'b0);
      push_byte(CHR_NUL, 1'b0);
      push_byte(CHR_QUOTE, 1'b1);
      push_byte(CHR_QUOTE, 1'b0);
      push_byte(CHR_BACKSLASH, 1'b0);
      push_byte(CHR_NUL, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(CHR_NUL, 1'b1);
      wait_for_idle();

      phase = 0;
      while (bytes_queued < BYTE_BUDGET) begin
         case (phase)
            0: begin depth = 8'd1;   limit = 24'hFFFFFF; end
            1: begin depth = 8'd255; limit = 24'd1;      end
            2: begin depth = 8'd0;   limit = 24'd0;      end
            3: begin depth = 8'd2;   limit = 24'd12;     end
            4: begin depth = 8'd3;   limit = 24'd30;     end
            5: begin depth = DEPTH_LIMIT_RESET; limit = LENGTH_LIMIT_RESET; end
            6: begin depth = 8'd255; limit = 24'hFFFFFF; end
            default: begin
               depth = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(1, 6));
               limit = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(1, 24'hFFFFFF))
                                                   : 24'($urandom_range(1, 48));
            end
         endcase
         // upper data bits are ignored by the depth register
         word       = 24'($urandom());
         word[7:0]  = depth;
         if ($urandom_range(0, 1)) begin
            write_register(CSR_DEPTH_LIMIT, word);
            write_register(CSR_LENGTH_LIMIT, limit);
         end else begin
            write_register(CSR_LENGTH_LIMIT, limit);
            write_register(CSR_DEPTH_LIMIT, word);
         end
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) queue_document(depth);
         wait_for_idle();
         phase++;
      end

      wait_for_idle();
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ json_nesting_depth_guard.f @@
hw/rtl/jndg_pkg.sv
hw/rtl/json_nesting_depth_guard.sv
test/tb_json_nesting_depth_guard.sv
